// File: rtl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants for the array list engine: word formats,
// operation and status codes, controller states, and the control/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ale_pkg;

    // Store geometry
    localparam int CAPACITY = 1024;
    localparam int AW       = $clog2(CAPACITY);       // element address bits
    localparam int CW       = $clog2(CAPACITY + 1);   // element count bits

    // Operation codes
    typedef enum logic [2:0] {
        OP_GET    = 3'd0,
        OP_SET    = 3'd1,
        OP_APPEND = 3'd2,
        OP_INSERT = 3'd3,
        OP_REMOVE = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INDEX = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Request word
    typedef struct packed {
        logic        [2:0]  op;
        logic        [9:0]  index;
        logic signed [31:0] value;
    } t_in;

    // Result word
    typedef struct packed {
        logic signed [31:0] read_value;
        logic        [1:0]  status;
        logic        [10:0] count;
    } t_out;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_GET_CAP,
        S_INS_SH,
        S_INS_WR,
        S_REM_CAP,
        S_REM_SH,
        S_REM_CLR,
        S_FIN
    } t_state;

    // Pointer update; the read port always addresses the next pointer value
    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_IDX,
        PTR_CNT_M1,
        PTR_INC,
        PTR_DEC
    } t_ptr_op;

    // Write address select
    typedef enum logic [2:0] {
        WA_IDX,
        WA_CNT,
        WA_CNT_M1,
        WA_PTR_P1,
        WA_PTR_M1
    } t_waddr;

    // Write data select
    typedef enum logic [1:0] {
        WD_VAL,
        WD_RDATA,
        WD_ZERO
    } t_wdata;

    // Count update
    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    // Controller to datapath
    typedef struct packed {
        logic    in_load;   // latch request, precompute status
        logic    rd_en;     // read store at next pointer
        t_ptr_op ptr_op;
        logic    wr_en;
        t_waddr  wr_addr;
        t_wdata  wr_data;
        logic    rv_cap;    // capture read word into result value
        t_cnt_op cnt_op;
        logic    out_load;  // push result into output register
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic       err;      // status of latched request is not ok
        logic       ins_more; // insert shift still above the index
        logic       rem_more; // remove shift has a higher element left
        logic       out_free; // output register can take a word
        logic [CW-1:0] count;
    } t_stat;

endpackage

// File: rtl/ale_dp.sv
// ----------------------------------------------------------------------------
// ale_dp
// Datapath: request latch, element store, shift pointer, element count,
// result value and the output register.
// ----------------------------------------------------------------------------
module ale_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ale_pkg::t_in  i_data,
    input  ale_pkg::t_cmd i_cmd,
    input  logic          i_ready,
    output ale_pkg::t_stat o_stat,
    output logic          o_valid,
    output ale_pkg::t_out o_data
);
    import ale_pkg::*;

    logic [31:0]   r_mem [CAPACITY];
    logic [31:0]   r_rdata;
    logic [2:0]    r_op;
    logic [9:0]    r_idx;
    logic [31:0]   r_val;
    logic [1:0]    r_st;
    logic [31:0]   r_rv;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] n_ptr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_out_valid;
    t_out          r_out;
    logic [AW-1:0] w_waddr;
    logic [31:0]   w_wdata;
    logic          w_needs_idx;
    logic          w_grows;
    logic [1:0]    w_st;

    // Status of an incoming request against the current count
    always_comb begin
        w_needs_idx = (i_data.op == OP_GET) || (i_data.op == OP_SET) ||
                      (i_data.op == OP_INSERT) || (i_data.op == OP_REMOVE);
        w_grows     = (i_data.op == OP_APPEND) || (i_data.op == OP_INSERT);
        if (w_needs_idx && (32'(i_data.index) >= 32'(r_count))) begin
            w_st = ST_INDEX;
        end else if (w_grows && (32'(r_count) >= 32'(CAPACITY))) begin
            w_st = ST_FULL;
        end else begin
            w_st = ST_OK;
        end
    end

    // Request latch and result value
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_op  <= i_data.op;
            r_idx <= i_data.index;
            r_val <= i_data.value;
            r_st  <= w_st;
            r_rv  <= '0;
        end else if (i_cmd.rv_cap) begin
            r_rv  <= r_rdata;
        end
    end

    // Pointer next value; also the read address
    always_comb begin
        case (i_cmd.ptr_op)
            PTR_IDX:    n_ptr = AW'(r_idx);
            PTR_CNT_M1: n_ptr = AW'(r_count - CW'(1));
            PTR_INC:    n_ptr = r_ptr + AW'(1);
            PTR_DEC:    n_ptr = r_ptr - AW'(1);
            default:    n_ptr = r_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
    end

    // Element count
    always_comb begin
        case (i_cmd.cnt_op)
            CNT_INC: n_count = r_count + CW'(1);
            CNT_DEC: n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Write address and data
    always_comb begin
        case (i_cmd.wr_addr)
            WA_CNT:    w_waddr = AW'(r_count);
            WA_CNT_M1: w_waddr = AW'(r_count - CW'(1));
            WA_PTR_P1: w_waddr = r_ptr + AW'(1);
            WA_PTR_M1: w_waddr = r_ptr - AW'(1);
            default:   w_waddr = AW'(r_idx);
        endcase
        case (i_cmd.wr_data)
            WD_RDATA: w_wdata = r_rdata;
            WD_ZERO:  w_wdata = '0;
            default:  w_wdata = r_val;
        endcase
    end

    // Element store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[n_ptr];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.read_value <= r_rv;
            r_out.status     <= r_st;
            r_out.count      <= 11'(r_count);
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.op       = r_op;
        o_stat.err      = (r_st != ST_OK);
        o_stat.ins_more = (r_ptr > AW'(r_idx));
        o_stat.rem_more = ((32'(r_ptr) + 32'd1) < 32'(r_count));
        o_stat.out_free = !r_out_valid || i_ready;
        o_stat.count    = r_count;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// File: rtl/ale_ctrl.sv
// ----------------------------------------------------------------------------
// ale_ctrl
// Controller: sequences one request at a time through decode, store
// reads and writes, the shift loop and result delivery.
// ----------------------------------------------------------------------------
module ale_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ale_pkg::t_stat i_stat,
    output logic           o_ready,
    output ale_pkg::t_cmd  o_cmd
);
    import ale_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state        = r_state;
        o_ready        = 1'b0;
        o_cmd.in_load  = 1'b0;
        o_cmd.rd_en    = 1'b0;
        o_cmd.ptr_op   = PTR_HOLD;
        o_cmd.wr_en    = 1'b0;
        o_cmd.wr_addr  = WA_IDX;
        o_cmd.wr_data  = WD_VAL;
        o_cmd.rv_cap   = 1'b0;
        o_cmd.cnt_op   = CNT_HOLD;
        o_cmd.out_load = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.in_load = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FIN;
                if (!i_stat.err) begin
                    case (i_stat.op)
                        OP_GET: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.ptr_op = PTR_IDX;
                            n_state      = S_GET_CAP;
                        end
                        OP_SET: begin
                            o_cmd.wr_en = 1'b1;
                        end
                        OP_APPEND: begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_addr = WA_CNT;
                            o_cmd.cnt_op  = CNT_INC;
                        end
                        OP_INSERT: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.ptr_op = PTR_CNT_M1;
                            n_state      = S_INS_SH;
                        end
                        OP_REMOVE: begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.ptr_op = PTR_IDX;
                            n_state      = S_REM_CAP;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_GET_CAP: begin
                o_cmd.rv_cap = 1'b1;
                n_state      = S_FIN;
            end
            // move the word just read up one slot, read the one below it
            S_INS_SH: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = WA_PTR_P1;
                o_cmd.wr_data = WD_RDATA;
                if (i_stat.ins_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.ptr_op = PTR_DEC;
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.cnt_op = CNT_INC;
                n_state      = S_FIN;
            end
            S_REM_CAP: begin
                o_cmd.rv_cap = 1'b1;
                if (i_stat.rem_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.ptr_op = PTR_INC;
                    n_state      = S_REM_SH;
                end else begin
                    n_state = S_REM_CLR;
                end
            end
            // move the word just read down one slot, read the one above it
            S_REM_SH: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = WA_PTR_M1;
                o_cmd.wr_data = WD_RDATA;
                if (i_stat.rem_more) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.ptr_op = PTR_INC;
                end else begin
                    n_state = S_REM_CLR;
                end
            end
            // clear the vacated last slot
            S_REM_CLR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_addr = WA_CNT_M1;
                o_cmd.wr_data = WD_ZERO;
                o_cmd.cnt_op  = CNT_DEC;
                n_state       = S_FIN;
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/array_list_engine_unit.sv
// ----------------------------------------------------------------------------
// array_list_engine_unit
// Ordered list of signed 32-bit words with get, set, append, insert and
// remove, one result word per request word.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. Get loads its result after decode, a
// store read and a capture, set and append right after decode, and the next
// request word is taken in the cycle after the result is loaded. Insert and
// remove move every word between the index and the end of the list through
// the element store, one word per cycle. A request that fails its index or
// full check goes from decode straight to the result and leaves the list
// untouched. The result sits in an output register, so a waiting result does
// not hold the engine beyond the end of the next request.
// The element store is not cleared by reset; only positions below the count
// are ever read.
module array_list_engine_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ale_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output ale_pkg::t_out o_data
);
    import ale_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    ale_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (w_stat),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    ale_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (w_cmd),
        .i_ready (i_ready),
        .o_stat  (w_stat),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    // Count never passes the store capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_stat.count) <= 32'(CAPACITY))
        else $error("element count above capacity");

    // A full error is only reported on a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.status == ST_FULL)) |-> (o_data.count == 11'(CAPACITY)))
        else $error("full status with list not full");

    // Failed requests return a zero word
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_data.status != ST_OK)) |-> (o_data.read_value == '0))
        else $error("nonzero read word on error");

    // One request at a time: no accept in the cycle after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while busy");

endmodule
